// ===== rtl/core/gcm_pkg.sv =====
package gcm_pkg;

  localparam int AMOUNT_W  = 24;
  localparam int COIN_W    = 16;
  localparam int USE_W     = 3;
  localparam int BIT_CNT_W = $clog2(AMOUNT_W);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // Register index of the slot count; slots sit at indexes below it
  localparam logic [2:0] REG_COINS_IN_USE = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/greedy_change_maker.sv =====
// Greedy coin change engine.
// Configure the denominations over the APB port: slot i at byte address 4*i,
// the slot count (coins_in_use) at address 28. Write only while busy is low.
// Issue a transaction by raising start with amount while busy is low; busy
// then stays high until the cycle that shows the last result.
// Results appear on coin_value, coin_count, left_over and last, each for
// exactly one cycle with result_valid high, largest denomination first; only
// denominations actually used are reported, and last marks the final one.
// With no coin used a single result carries value 0, count 0 and the whole
// amount as left_over.
// Per transaction the block makes one pass per distinct denomination. Each pass
// scans the slots one per cycle for the next smaller denomination, then runs a
// bit-serial restoring divider; a closing scan and the finish state follow. The
// next amount can be taken in the same cycle that shows the last result.
// The receiver cannot stall; each result must be taken in its cycle.
// Reset (synchronous, rst high) clears the configuration, result_valid and
// pend_valid and idles the block; no result is pending after reset.
module greedy_change_maker #(
  parameter int NUM_SLOTS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcm_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcm_pkg::DATA_W-1:0]    pwdata,
  output logic [gcm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  input  logic [gcm_pkg::AMOUNT_W-1:0]  amount,
  output logic                          busy,
  output logic                          result_valid,
  output logic [gcm_pkg::COIN_W-1:0]    coin_value,
  output logic [gcm_pkg::AMOUNT_W-1:0]  coin_count,
  output logic [gcm_pkg::AMOUNT_W-1:0]  left_over,
  output logic                          last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [gcm_pkg::COIN_W-1:0]    coin_reg [NUM_SLOTS];
  logic [gcm_pkg::USE_W-1:0]     coins_in_use;

  gcm_pkg::state_t               state, state_next;

  logic [gcm_pkg::USE_W-1:0]     slot;
  logic [gcm_pkg::USE_W-1:0]     used;
  logic                          scan_active;
  logic [gcm_pkg::COIN_W-1:0]    slot_val;
  logic [gcm_pkg::COIN_W-1:0]    best;
  logic [gcm_pkg::COIN_W-1:0]    prev;
  logic                          first;
  logic [gcm_pkg::AMOUNT_W-1:0]  rem;

  logic [gcm_pkg::COIN_W-1:0]    part;
  logic [gcm_pkg::AMOUNT_W-1:0]  quo;
  logic [gcm_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [gcm_pkg::COIN_W:0]      trial;
  logic                          q_bit;
  logic [gcm_pkg::COIN_W-1:0]    part_next;
  logic [gcm_pkg::AMOUNT_W-1:0]  quo_next;
  logic                          div_done;

  logic                          pend_valid;
  logic [gcm_pkg::COIN_W-1:0]    pend_value;
  logic [gcm_pkg::AMOUNT_W-1:0]  pend_count;
  logic [gcm_pkg::AMOUNT_W-1:0]  pend_left;

  logic                          cfg_write;
  logic [2:0]                    cfg_idx;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        coin_reg[i] <= '0;
      end
      coins_in_use <= '0;
    end else if (cfg_write) begin
      if (cfg_idx == gcm_pkg::REG_COINS_IN_USE) begin
        coins_in_use <= pwdata[gcm_pkg::USE_W-1:0];
      end else if (cfg_idx < 3'(NUM_SLOTS)) begin
        coin_reg[cfg_idx[IDX_W-1:0]] <= pwdata[gcm_pkg::COIN_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == gcm_pkg::REG_COINS_IN_USE) begin
      prdata = {{(gcm_pkg::DATA_W-gcm_pkg::USE_W){1'b0}}, coins_in_use};
    end else if (cfg_idx < 3'(NUM_SLOTS)) begin
      prdata = {{(gcm_pkg::DATA_W-gcm_pkg::COIN_W){1'b0}}, coin_reg[cfg_idx[IDX_W-1:0]]};
    end
  end

  // Scan: slots beyond the implemented ones are never considered
  assign used        = (coins_in_use > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : coins_in_use;
  assign scan_active = (slot < used);
  assign slot_val    = scan_active ? coin_reg[slot[IDX_W-1:0]] : '0;

  // One restoring division step
  assign trial     = {part, quo[gcm_pkg::AMOUNT_W-1]};
  assign q_bit     = (trial >= {1'b0, best});
  assign part_next = q_bit ? gcm_pkg::COIN_W'(trial - {1'b0, best})
                           : trial[gcm_pkg::COIN_W-1:0];
  assign quo_next  = {quo[gcm_pkg::AMOUNT_W-2:0], q_bit};
  assign div_done  = (bit_cnt == gcm_pkg::BIT_CNT_W'(gcm_pkg::AMOUNT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      gcm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = gcm_pkg::ST_SCAN;
        end
      end
      gcm_pkg::ST_SCAN: begin
        if (!scan_active) begin
          state_next = (best == '0) ? gcm_pkg::ST_FINISH : gcm_pkg::ST_DIV;
        end
      end
      gcm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = gcm_pkg::ST_SCAN;
        end
      end
      gcm_pkg::ST_FINISH: begin
        state_next = gcm_pkg::ST_IDLE;
      end
      default: begin
        state_next = gcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath; a found result is held back until the next one or the end,
  // so that last can be set on the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      case (state)
        gcm_pkg::ST_IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            rem        <= amount;
            first      <= 1'b1;
            slot       <= '0;
            best       <= '0;
            pend_valid <= 1'b0;
          end
        end
        gcm_pkg::ST_SCAN: begin
          result_valid <= 1'b0;
          if (scan_active) begin
            if (slot_val != '0 && (first || slot_val < prev) && slot_val > best) begin
              best <= slot_val;
            end
            slot <= slot + 1'b1;
          end else begin
            part    <= '0;
            quo     <= rem;
            bit_cnt <= '0;
          end
        end
        gcm_pkg::ST_DIV: begin
          result_valid <= div_done && (quo_next != '0) && pend_valid;
          part    <= part_next;
          quo     <= quo_next;
          bit_cnt <= bit_cnt + 1'b1;
          if (div_done) begin
            rem   <= {{(gcm_pkg::AMOUNT_W-gcm_pkg::COIN_W){1'b0}}, part_next};
            prev  <= best;
            first <= 1'b0;
            best  <= '0;
            slot  <= '0;
            if (quo_next != '0) begin
              if (pend_valid) begin
                coin_value   <= pend_value;
                coin_count   <= pend_count;
                left_over    <= pend_left;
                last         <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_value <= best;
              pend_count <= quo_next;
              pend_left  <= {{(gcm_pkg::AMOUNT_W-gcm_pkg::COIN_W){1'b0}}, part_next};
            end
          end
        end
        gcm_pkg::ST_FINISH: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          if (pend_valid) begin
            coin_value <= pend_value;
            coin_count <= pend_count;
            left_over  <= pend_left;
          end else begin
            coin_value <= '0;
            coin_count <= '0;
            left_over  <= rem;
          end
          pend_valid <= 1'b0;
        end
        default: begin
          result_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int SLOT_COUNT     = 7;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES   = 230;
  localparam int ITEMS_PER_CFG  = 40;

  typedef struct packed {
    logic [gcm_pkg::COIN_W-1:0]   coin;
    logic [gcm_pkg::AMOUNT_W-1:0] count;
    logic [gcm_pkg::AMOUNT_W-1:0] rest;
    logic                         fin;
  } payout_t;

  // Holds the register image and the coins still owed, oldest first
  class payout_ledger;
    logic [gcm_pkg::COIN_W-1:0] slot_coin [SLOT_COUNT];
    int unsigned                slots_on;
    payout_t                    due_q [$];
    int unsigned                errors;
    int unsigned                amounts_taken;
    int unsigned                results_checked;

    function new();
      foreach (slot_coin[i]) slot_coin[i] = '0;
      slots_on        = 0;
      errors          = 0;
      amounts_taken   = 0;
      results_checked = 0;
    endfunction

    function void set_register(int unsigned idx, logic [gcm_pkg::DATA_W-1:0] data);
      if (idx < SLOT_COUNT) slot_coin[idx] = data[gcm_pkg::COIN_W-1:0];
      else if (idx == int'(gcm_pkg::REG_COINS_IN_USE))
        slots_on = 32'(data[gcm_pkg::USE_W-1:0]);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Walk the distinct denominations from the largest down, paying what fits
    function void note_amount(logic [gcm_pkg::AMOUNT_W-1:0] amt);
      int unsigned rest;
      int unsigned ceiling;
      int unsigned best;
      int unsigned cnt;
      int unsigned span;
      int unsigned produced;
      payout_t     item;
      rest     = 32'(amt);
      ceiling  = 32'h10000;
      produced = 0;
      span     = (slots_on > SLOT_COUNT) ? SLOT_COUNT : slots_on;
      amounts_taken++;
      for (int pass = 0; pass < SLOT_COUNT; pass++) begin
        best = 0;
        for (int i = 0; i < span; i++) begin
          if (slot_coin[i] != 0 && slot_coin[i] < ceiling && slot_coin[i] > best)
            best = 32'(slot_coin[i]);
        end
        if (best == 0) break;
        ceiling = best;
        cnt = rest / best;
        if (cnt != 0) begin
          rest       = rest - cnt * best;
          item.coin  = gcm_pkg::COIN_W'(best);
          item.count = gcm_pkg::AMOUNT_W'(cnt);
          item.rest  = gcm_pkg::AMOUNT_W'(rest);
          item.fin   = 1'b0;
          due_q.push_back(item);
          produced++;
        end
      end
      if (produced == 0) begin
        item.coin  = '0;
        item.count = '0;
        item.rest  = gcm_pkg::AMOUNT_W'(rest);
        item.fin   = 1'b1;
        due_q.push_back(item);
      end else begin
        item     = due_q.pop_back();
        item.fin = 1'b1;
        due_q.push_back(item);
      end
    endfunction

    function void check_coin(logic [gcm_pkg::COIN_W-1:0] coin,
                             logic [gcm_pkg::AMOUNT_W-1:0] count,
                             logic [gcm_pkg::AMOUNT_W-1:0] rest, logic fin);
      payout_t want;
      if (due_q.size() == 0) begin
        $error("unexpected result: coin_value %0d coin_count %0d left_over %0d last %0b",
               coin, count, rest, fin);
        errors++;
        return;
      end
      want = due_q.pop_front();
      results_checked++;
      if (coin !== want.coin) begin
        $error("coin_value mismatch: expected %0d, got %0d", want.coin, coin);
        errors++;
      end
      if (count !== want.count) begin
        $error("coin_count mismatch: expected %0d, got %0d", want.count, count);
        errors++;
      end
      if (rest !== want.rest) begin
        $error("left_over mismatch: expected %0d, got %0d", want.rest, rest);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("last mismatch: expected %0b, got %0b", want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                         clk     = 1'b0;
  logic                         rst     = 1'b1;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [gcm_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [gcm_pkg::DATA_W-1:0]   pwdata  = '0;
  logic [gcm_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         start   = 1'b0;
  logic [gcm_pkg::AMOUNT_W-1:0] amount  = '0;
  logic                         busy;
  logic                         result_valid;
  logic [gcm_pkg::COIN_W-1:0]   coin_value;
  logic [gcm_pkg::AMOUNT_W-1:0] coin_count;
  logic [gcm_pkg::AMOUNT_W-1:0] left_over;
  logic                         last;

  payout_ledger               ledger = new();
  logic [gcm_pkg::COIN_W-1:0] slot_plan [SLOT_COUNT];
  int unsigned                settings_applied = 0;
  int unsigned                cycle_count = 0;

  greedy_change_maker #(
    .NUM_SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .amount      (amount),
    .busy        (busy),
    .result_valid(result_valid),
    .coin_value  (coin_value),
    .coin_count  (coin_count),
    .left_over   (left_over),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) ledger.check_coin(coin_value, coin_count, left_over, last);
  end

  // Leave one idle cycle after the access so that the bus is driven once per edge
  task automatic write_reg(int unsigned idx, logic [gcm_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gcm_pkg::ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_register(idx, data);
    @(posedge clk);
  endtask

  // Upper data bits carry noise: the block must mask them off
  task automatic apply_setting(int unsigned in_use);
    logic [gcm_pkg::DATA_W-1:0] data;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      data = $urandom();
      data[gcm_pkg::COIN_W-1:0] = slot_plan[i];
      write_reg(i, data);
    end
    data = $urandom();
    data[gcm_pkg::USE_W-1:0] = gcm_pkg::USE_W'(in_use);
    write_reg(int'(gcm_pkg::REG_COINS_IN_USE), data);
    settings_applied++;
  endtask

  task automatic load_random_setting();
    int unsigned pick;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) slot_plan[i] = '0;
      else if (pick < 20 && i > 0) slot_plan[i] = slot_plan[$urandom_range(i - 1)];
      else if (pick < 55) slot_plan[i] = gcm_pkg::COIN_W'($urandom_range(1, 25));
      else if (pick < 80) slot_plan[i] = gcm_pkg::COIN_W'($urandom_range(1, 4095));
      else slot_plan[i] = gcm_pkg::COIN_W'($urandom_range(1, 65535));
    end
    apply_setting(($urandom_range(3) == 0) ? $urandom_range(0, 7) : 7);
  endtask

  // Hold start until the block takes the transaction
  task automatic send_amount(logic [gcm_pkg::AMOUNT_W-1:0] amt);
    start  <= 1'b1;
    amount <= amt;
    do @(posedge clk); while (busy);
    ledger.note_amount(amt);
  endtask

  // Drop start and wait for every owed coin before touching the registers
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [gcm_pkg::AMOUNT_W-1:0] pick_amount();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return gcm_pkg::AMOUNT_W'($urandom());
    if (roll < 70) return gcm_pkg::AMOUNT_W'($urandom_range(0, 200000));
    if (roll < 90) return gcm_pkg::AMOUNT_W'($urandom_range(0, 300));
    if (roll < 95) return '0;
    return '1;
  endfunction

  task automatic run_phase(int unsigned idle_pct, int unsigned count);
    for (int k = 0; k < count; k++) begin
      if (k % ITEMS_PER_CFG == 0) begin
        settle();
        load_random_setting();
      end
      if (idle_pct != 0 && $urandom_range(7) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 250)) @(posedge clk);
      end
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send_amount(pick_amount());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: nothing can be paid
    send_amount('0);
    send_amount('1);
    settle();

    // Unsorted slots with an empty slot and a repeated value
    slot_plan = '{16'd1, 16'd5, 16'd10, 16'd25, 16'd0, 16'd10, 16'hFFFF};
    apply_setting(7);
    send_amount('0);
    send_amount('1);
    send_amount(24'd4);
    send_amount(24'd65535);
    send_amount(24'd65534);
    send_amount(24'd65576);
    send_amount(24'd99);
    settle();

    // Only the first three slots count; every coin can exceed the amount
    slot_plan = '{16'd300, 16'd100, 16'd200, 16'd7, 16'd7, 16'd7, 16'd7};
    apply_setting(3);
    send_amount(24'd50);
    send_amount(24'd600);
    send_amount(24'd599);
    send_amount('1);
    settle();

    // Unit coin alone gives the largest count
    slot_plan = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    apply_setting(1);
    send_amount('1);
    send_amount('0);
    settle();

    slot_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    apply_setting(7);
    send_amount('1);
    send_amount(24'd65534);
    send_amount(24'd65535);
    settle();

    apply_setting(0);
    send_amount(24'd12345);

    run_phase(24, 134);
    run_phase(61, 133);
    run_phase(0, 133);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.pending() != 0) begin
      $error("%0d coin results never arrived", ledger.pending());
      ledger.errors++;
    end

    $display("Paid out %0d amounts under %0d register settings; %0d coin results checked.",
             ledger.amounts_taken, settings_applied, ledger.results_checked);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gcm_pkg.sv
rtl/core/greedy_change_maker.sv
tb/testbench.sv
